// ===== rtl/swms_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swms_pkg
// Types and constants shared by the sliding window mean statistics block.
// ----------------------------------------------------------------------------
package swms_pkg;

   localparam int CFG_REGS = 8;
   localparam int CFG_BITS = 10;
   localparam int CSR_INDEX_BITS = 3;

   // register indexes
   localparam logic [CSR_INDEX_BITS-1:0] CSR_WINDOWS    = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPLITS     = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_METRICS    = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_LONGEST    = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_WIN_LEN_A  = 3'd4;

   localparam int COUNT_BITS = 3;
   localparam int HIT_BITS = 32;
   localparam int DIV_STEPS = 64;
   localparam int MILLI = 1000;
   // largest quotient that can still be scaled by 1000 in 64 bits
   localparam logic [63:0] MEAN_Q_LIMIT = 64'd18446744073709551;

   typedef enum logic {
      CMD_SAMPLE = 1'b0,
      CMD_REPORT = 1'b1
   } command_type;

   typedef struct packed {
      logic        command;
      logic [31:0] now_seconds;
      logic [1:0]  split_index;
      logic [1:0]  metric_index;
      logic [63:0] sample_value;
   } req_type;

   typedef struct packed {
      logic [1:0]  window_index;
      logic [1:0]  split_out;
      logic [1:0]  metric_out;
      logic [63:0] mean_milli;
      logic [31:0] report_time;
      logic        last_of_report;
   } rsp_type;

endpackage

// ===== rtl/swms_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swms_ram
// Simple dual port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module swms_ram #(
   parameter int WIDTH = 96,
   parameter int DEPTH = 8192
) (
   input  logic                                         clock,
   input  logic                                         we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                             wdata,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                             rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

// ===== rtl/sliding_window_mean_stats_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sliding_window_mean_stats_core
// Per-second ring of sample sums with running window sums and mean reports.
//
//   channel | dir | handshake           | payload
//   req     | in  | req_valid/req_stall | req_data (swms_pkg::req_type)
//   rsp     | out | rsp_valid/rsp_stall | rsp_data (swms_pkg::rsp_type)
//   csr     | in  | csr_write           | csr_index, csr_data
//
// after reset a clearing pass zeroes both memories; requests are stalled
// meanwhile, csr writes are taken.
// each window with expired seconds takes a slot modulo on the shared
// 64-step divider, then a read and a write per expired second per active
// split and metric. a sample then takes one more modulo and a read-modify-write
// of its ring slot and of each window sum; a report takes two divider passes
// per result (none when the count is zero).
// one request at a time; results wait in an output register under rsp_stall.
// ----------------------------------------------------------------------------
module sliding_window_mean_stats_core #(
   parameter int MAX_WINDOWS  = 4,
   parameter int MAX_SPLITS   = 4,
   parameter int MAX_METRICS  = 4,
   parameter int RING_SECONDS = 512,
   parameter int SUM_BITS     = 64
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  swms_pkg::req_type                    req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output swms_pkg::rsp_type                    rsp_data,
   input  logic                                 csr_write,
   input  logic [swms_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [swms_pkg::CFG_BITS-1:0]        csr_data
);

   import swms_pkg::*;

   localparam int GROUP      = MAX_SPLITS * MAX_METRICS;
   localparam int RING_DEPTH = RING_SECONDS * GROUP;
   localparam int WIN_DEPTH  = MAX_WINDOWS * GROUP;
   localparam int CLR_DEPTH  = (RING_DEPTH > WIN_DEPTH) ? RING_DEPTH : WIN_DEPTH;
   localparam int RAW        = $clog2(RING_DEPTH);
   localparam int WAW        = (WIN_DEPTH > 1) ? $clog2(WIN_DEPTH) : 1;
   localparam int CLW        = $clog2(CLR_DEPTH);
   localparam int DW         = SUM_BITS + HIT_BITS;
   localparam int WCW        = $clog2(MAX_WINDOWS + 1);
   localparam int SCW        = $clog2(MAX_SPLITS + 1);
   localparam int MCW        = $clog2(MAX_METRICS + 1);
   localparam int WIW        = (MAX_WINDOWS > 1) ? $clog2(MAX_WINDOWS) : 1;
   localparam int LW         = $clog2(RING_SECONDS + 1);
   localparam int SLW        = $clog2(RING_SECONDS);
   localparam int DCW        = $clog2(DIV_STEPS);

   typedef enum logic [4:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EXP_WIN,
      ST_EXP_SLOT,
      ST_EXP_RD,
      ST_EXP_WR,
      ST_DIV,
      ST_ADD_SLOT,
      ST_ADD_RING_RD,
      ST_ADD_RING_WR,
      ST_ADD_WIN_RD,
      ST_ADD_WIN_WR,
      ST_REP_RD,
      ST_REP_LOAD,
      ST_REP_MUL,
      ST_REP_SUM,
      ST_EMIT
   } state_type;

   state_type          state_ff;
   state_type          ret_ff;
   logic [CFG_BITS-1:0] cfg_ff [CFG_REGS];
   req_type            req_ff;
   logic [31:0]        prev_report_ff;
   logic [31:0]        expired_ff [MAX_WINDOWS];
   logic [CLW-1:0]     clr_ff;
   logic [WCW-1:0]     w_ff;
   logic [SCW-1:0]     s_ff;
   logic [MCW-1:0]     m_ff;
   logic [SLW-1:0]     slot_ff;
   logic [LW-1:0]      walk_ff;
   logic               clears_ff;
   logic [HIT_BITS-1:0] hits_ff;
   logic [63:0]        base_ff;
   logic [63:0]        mean_ff;
   logic [63:0]        div_num_ff;
   logic [32:0]        div_den_ff;
   logic [33:0]        div_rem_ff;
   logic [DCW-1:0]     div_cnt_ff;
   logic               rsp_valid_ff;
   rsp_type            rsp_data_ff;

   // divider step
   logic [33:0]        div_shift;
   logic               div_ge;
   logic [33:0]        div_rem_in;
   logic [63:0]        div_num_in;

   // derived configuration
   logic [WCW-1:0]     num_win;
   logic [SCW-1:0]     num_split;
   logic [MCW-1:0]     num_metric;
   logic [LW-1:0]      ring_len;
   logic [CFG_BITS-1:0] win_len;
   logic [32:0]        now_p1;
   logic [31:0]        exp_target;
   logic [31:0]        exp_last;
   logic [31:0]        exp_steps;
   logic               exp_skip;
   logic [LW-1:0]      exp_walk;
   logic               exp_clears;
   logic               m_last;
   logic               s_last;
   logic               w_last;
   logic               slot_wrap;

   // memories
   logic               ring_we;
   logic [RAW-1:0]     ring_addr;
   logic [DW-1:0]      ring_wdata;
   logic [DW-1:0]      ring_rdata;
   logic               win_we;
   logic [WAW-1:0]     win_addr;
   logic [DW-1:0]      win_wdata;
   logic [DW-1:0]      win_rdata;

   // add unit
   logic [DW-1:0]       add_old;
   logic [SUM_BITS-1:0] add_value;
   logic [SUM_BITS-1:0] add_sum;
   logic [DW-1:0]       add_res;
   logic [64:0]         mean_total;

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign div_shift  = {div_rem_ff[32:0], div_num_ff[63]};
   assign div_ge     = (div_shift >= {1'b0, div_den_ff});
   assign div_rem_in = div_ge ? (div_shift - {1'b0, div_den_ff}) : div_shift;
   assign div_num_in = {div_num_ff[62:0], div_ge};

   always_comb begin
      int nw_i;
      int ns_i;
      int nm_i;
      int l_i;
      int len_i;
      nw_i = int'(cfg_ff[CSR_WINDOWS]);
      if (nw_i < 1) nw_i = 1;
      if (nw_i > MAX_WINDOWS) nw_i = MAX_WINDOWS;
      ns_i = int'(cfg_ff[CSR_SPLITS]);
      if (ns_i < 1) ns_i = 1;
      if (ns_i > MAX_SPLITS) ns_i = MAX_SPLITS;
      nm_i = int'(cfg_ff[CSR_METRICS]);
      if (nm_i < 1) nm_i = 1;
      if (nm_i > MAX_METRICS) nm_i = MAX_METRICS;
      l_i = int'(cfg_ff[CSR_LONGEST]);
      if (l_i < 1) l_i = 1;
      if (l_i > RING_SECONDS) l_i = RING_SECONDS;
      // windows beyond the fourth have no length register and act as one second
      len_i = (int'(w_ff) < 4)
            ? int'(cfg_ff[CSR_INDEX_BITS'(int'(CSR_WIN_LEN_A) + int'(w_ff))]) : 1;
      if (len_i < 1) len_i = 1;

      num_win    = WCW'(nw_i);
      num_split  = SCW'(ns_i);
      num_metric = MCW'(nm_i);
      ring_len   = LW'(l_i);
      win_len    = CFG_BITS'(len_i);
      exp_clears = (len_i == l_i);

      now_p1     = {1'b0, req_ff.now_seconds} + 33'd1;
      exp_target = 32'(now_p1 - {23'd0, win_len});
      exp_last   = expired_ff[w_ff[WIW-1:0]];
      exp_skip   = (now_p1 < {23'd0, win_len}) || (exp_last >= exp_target);
      exp_steps  = exp_target - exp_last;
      exp_walk   = (exp_steps < 32'(ring_len)) ? LW'(exp_steps) : ring_len;

      m_last    = (int'(m_ff) + 1 >= nm_i);
      s_last    = (int'(s_ff) + 1 >= ns_i);
      w_last    = (int'(w_ff) + 1 >= nw_i);
      slot_wrap = (int'(slot_ff) + 1 >= l_i);
   end

   always_comb begin
      add_old    = (state_ff == ST_ADD_RING_WR) ? ring_rdata : win_rdata;
      add_value  = req_ff.sample_value[SUM_BITS-1:0];
      add_sum    = add_old[DW-1:HIT_BITS] + add_value;
      // a wrapping sum restarts with its count
      add_res    = (add_sum < add_value) ? '0
                 : {add_sum, add_old[HIT_BITS-1:0] + 32'd1};
      mean_total = {1'b0, base_ff} + {1'b0, div_num_ff};
   end

   always_comb begin
      ring_addr  = RAW'(int'(slot_ff) * GROUP + int'(s_ff) * MAX_METRICS + int'(m_ff));
      win_addr   = WAW'(int'(w_ff) * GROUP + int'(s_ff) * MAX_METRICS + int'(m_ff));
      ring_we    = 1'b0;
      ring_wdata = '0;
      win_we     = 1'b0;
      win_wdata  = '0;
      case (state_ff)
         ST_CLEAR: begin
            ring_addr = RAW'(clr_ff);
            win_addr  = WAW'(clr_ff);
            ring_we   = (int'(clr_ff) < RING_DEPTH);
            win_we    = (int'(clr_ff) < WIN_DEPTH);
         end
         ST_EXP_WR: begin
            win_we    = 1'b1;
            win_wdata = {win_rdata[DW-1:HIT_BITS] - ring_rdata[DW-1:HIT_BITS],
                         win_rdata[HIT_BITS-1:0] - ring_rdata[HIT_BITS-1:0]};
            ring_we   = clears_ff;
         end
         ST_ADD_RING_WR: begin
            ring_we    = 1'b1;
            ring_wdata = add_res;
         end
         ST_ADD_WIN_WR: begin
            win_we    = 1'b1;
            win_wdata = add_res;
         end
         default: begin
         end
      endcase
   end

   swms_ram #(
      .WIDTH (DW),
      .DEPTH (RING_DEPTH)
   ) u_ring_ram (
      .clock (clock),
      .we    (ring_we),
      .waddr (ring_addr),
      .wdata (ring_wdata),
      .raddr (ring_addr),
      .rdata (ring_rdata)
   );

   swms_ram #(
      .WIDTH (DW),
      .DEPTH (WIN_DEPTH)
   ) u_win_ram (
      .clock (clock),
      .we    (win_we),
      .waddr (win_addr),
      .wdata (win_wdata),
      .raddr (win_addr),
      .rdata (win_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CFG_REGS; i++) begin
            cfg_ff[i] <= CFG_BITS'(1);
         end
      end else if (csr_write) begin
         cfg_ff[csr_index] <= (csr_index < CSR_LONGEST)
                            ? (csr_data & CFG_BITS'(7)) : csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_CLEAR;
         ret_ff         <= ST_IDLE;
         clr_ff         <= '0;
         prev_report_ff <= '0;
         rsp_valid_ff   <= 1'b0;
         for (int i = 0; i < MAX_WINDOWS; i++) begin
            expired_ff[i] <= '0;
         end
      end else begin
         // the emit step handles the output register itself
         if (rsp_valid_ff && !rsp_stall && (state_ff != ST_EMIT)) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_CLEAR: begin
               clr_ff <= clr_ff + CLW'(1);
               if (int'(clr_ff) == CLR_DEPTH - 1) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_IDLE: begin
               if (req_valid) begin
                  req_ff <= req_data;
                  w_ff   <= '0;
                  if (req_data.command == CMD_REPORT) begin
                     // a repeated report second is dropped
                     if (req_data.now_seconds != prev_report_ff) begin
                        prev_report_ff <= req_data.now_seconds;
                        state_ff       <= ST_EXP_WIN;
                     end
                  end else begin
                     state_ff <= ST_EXP_WIN;
                  end
               end
            end
            ST_EXP_WIN: begin
               if (w_ff >= num_win) begin
                  w_ff <= '0;
                  s_ff <= '0;
                  m_ff <= '0;
                  if (req_ff.command == CMD_REPORT) begin
                     state_ff <= ST_REP_RD;
                  end else if ((int'(req_ff.split_index) >= int'(num_split)) ||
                               (int'(req_ff.metric_index) >= int'(num_metric))) begin
                     state_ff <= ST_IDLE;
                  end else begin
                     div_num_ff <= {32'd0, req_ff.now_seconds};
                     div_den_ff <= 33'(ring_len);
                     div_rem_ff <= '0;
                     div_cnt_ff <= '0;
                     ret_ff     <= ST_ADD_SLOT;
                     state_ff   <= ST_DIV;
                  end
               end else if (exp_skip) begin
                  w_ff <= w_ff + WCW'(1);
               end else begin
                  expired_ff[w_ff[WIW-1:0]] <= exp_target;
                  walk_ff    <= exp_walk;
                  clears_ff  <= exp_clears;
                  s_ff       <= '0;
                  m_ff       <= '0;
                  div_num_ff <= {32'd0, exp_last};
                  div_den_ff <= 33'(ring_len);
                  div_rem_ff <= '0;
                  div_cnt_ff <= '0;
                  ret_ff     <= ST_EXP_SLOT;
                  state_ff   <= ST_DIV;
               end
            end
            ST_DIV: begin
               div_rem_ff <= div_rem_in;
               div_num_ff <= div_num_in;
               div_cnt_ff <= div_cnt_ff + DCW'(1);
               if (div_cnt_ff == DCW'(DIV_STEPS - 1)) begin
                  state_ff <= ret_ff;
               end
            end
            ST_EXP_SLOT: begin
               slot_ff  <= SLW'(div_rem_ff);
               state_ff <= ST_EXP_RD;
            end
            ST_EXP_RD: begin
               state_ff <= ST_EXP_WR;
            end
            ST_EXP_WR: begin
               state_ff <= ST_EXP_RD;
               if (!m_last) begin
                  m_ff <= m_ff + MCW'(1);
               end else begin
                  m_ff <= '0;
                  if (!s_last) begin
                     s_ff <= s_ff + SCW'(1);
                  end else begin
                     s_ff    <= '0;
                     walk_ff <= walk_ff - LW'(1);
                     slot_ff <= slot_wrap ? '0 : slot_ff + SLW'(1);
                     if (walk_ff == LW'(1)) begin
                        w_ff     <= w_ff + WCW'(1);
                        state_ff <= ST_EXP_WIN;
                     end
                  end
               end
            end
            ST_ADD_SLOT: begin
               slot_ff  <= SLW'(div_rem_ff);
               s_ff     <= SCW'(req_ff.split_index);
               m_ff     <= MCW'(req_ff.metric_index);
               state_ff <= ST_ADD_RING_RD;
            end
            ST_ADD_RING_RD: begin
               state_ff <= ST_ADD_RING_WR;
            end
            ST_ADD_RING_WR: begin
               w_ff     <= '0;
               state_ff <= ST_ADD_WIN_RD;
            end
            ST_ADD_WIN_RD: begin
               state_ff <= ST_ADD_WIN_WR;
            end
            ST_ADD_WIN_WR: begin
               w_ff     <= w_ff + WCW'(1);
               state_ff <= w_last ? ST_IDLE : ST_ADD_WIN_RD;
            end
            ST_REP_RD: begin
               state_ff <= ST_REP_LOAD;
            end
            ST_REP_LOAD: begin
               hits_ff <= win_rdata[HIT_BITS-1:0];
               if (win_rdata[HIT_BITS-1:0] == '0) begin
                  mean_ff  <= '0;
                  state_ff <= ST_EMIT;
               end else begin
                  div_num_ff <= 64'(win_rdata[DW-1:HIT_BITS]);
                  div_den_ff <= {1'b0, win_rdata[HIT_BITS-1:0]};
                  div_rem_ff <= '0;
                  div_cnt_ff <= '0;
                  ret_ff     <= ST_REP_MUL;
                  state_ff   <= ST_DIV;
               end
            end
            ST_REP_MUL: begin
               if (div_num_ff > MEAN_Q_LIMIT) begin
                  mean_ff  <= '1;
                  state_ff <= ST_EMIT;
               end else begin
                  base_ff <= div_num_ff * 64'(MILLI);
                  // rounding term: (2000*r + hits) / (2*hits)
                  div_num_ff <= 64'(div_rem_ff[31:0]) * 64'(2 * MILLI) + 64'(hits_ff);
                  div_den_ff <= {hits_ff, 1'b0};
                  div_rem_ff <= '0;
                  div_cnt_ff <= '0;
                  ret_ff     <= ST_REP_SUM;
                  state_ff   <= ST_DIV;
               end
            end
            ST_REP_SUM: begin
               mean_ff  <= mean_total[64] ? '1 : mean_total[63:0];
               state_ff <= ST_EMIT;
            end
            ST_EMIT: begin
               if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_valid_ff                <= 1'b1;
                  rsp_data_ff.window_index    <= 2'(w_ff);
                  rsp_data_ff.split_out       <= 2'(s_ff);
                  rsp_data_ff.metric_out      <= 2'(m_ff);
                  rsp_data_ff.mean_milli      <= mean_ff;
                  rsp_data_ff.report_time     <= req_ff.now_seconds;
                  rsp_data_ff.last_of_report  <= w_last && s_last && m_last;
                  state_ff <= ST_REP_RD;
                  if (!m_last) begin
                     m_ff <= m_ff + MCW'(1);
                  end else begin
                     m_ff <= '0;
                     if (!s_last) begin
                        s_ff <= s_ff + SCW'(1);
                     end else begin
                        s_ff <= '0;
                        w_ff <= w_ff + WCW'(1);
                        if (w_last) begin
                           state_ff <= ST_IDLE;
                        end
                     end
                  end
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

`ifndef ASSERT_OFF
   // results only come out of the emit step
   a_rsp_from_emit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_EMIT))
      else $error("result raised outside emit");

   // nothing is reported while the memories are being cleared
   a_clear_quiet: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> !rsp_valid_ff)
      else $error("result during clearing pass");

   // partial remainder stays below the divisor
   a_div_rem: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (div_rem_ff < {1'b0, div_den_ff}))
      else $error("divider remainder out of range");
`endif

endmodule

// ===== dv/sliding_window_mean_stats_core_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sliding_window_mean_stats_core_test
// Drives sample and report requests into the window statistics core under
// random idling on both sides. A behavioral copy of the ring, the window sums
// and the mean rounding predicts every reported mean, which is checked in
// order, field by field.
// ----------------------------------------------------------------------------
module sliding_window_mean_stats_core_test;
   import swms_pkg::*;

   localparam int WINDOWS = 4;
   localparam int SPLITS = 4;
   localparam int METRICS = 4;
   localparam int RING = 512;
   localparam int GROUP = SPLITS * METRICS;
   localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

   logic clock = 1'b0;
   logic reset;
   logic req_valid;
   logic req_stall;
   req_type req_data;
   logic rsp_valid;
   logic rsp_stall;
   rsp_type rsp_data;
   logic csr_write;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [CFG_BITS-1:0] csr_data;

   sliding_window_mean_stats_core i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data)
   );

   // model of the block state
   longint unsigned ring_total[RING*GROUP];
   int unsigned ring_count[RING*GROUP];
   longint unsigned win_total[WINDOWS*GROUP];
   int unsigned win_count[WINDOWS*GROUP];
   int unsigned expired_to[WINDOWS];
   int unsigned last_report_sec;
   int unsigned csr_shadow[CFG_REGS];
   int unsigned busy_estimate;

   rsp_type pending_means[$];
   int error_count = 0;
   bit send_idle;
   bit recv_idle;
   int hold_cycles = 0;
   int hold_req = 0;
   int hold_seen = 0;
   int recv_wait;
   int unsigned clock_sec;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic int unsigned clamp_count(int unsigned v, int unsigned hi);
      if (v < 1) return 1;
      return (v > hi) ? hi : v;
   endfunction

   function automatic int unsigned ring_span();
      return clamp_count(csr_shadow[CSR_LONGEST], RING);
   endfunction

   function automatic int unsigned window_span(int w);
      int unsigned v;
      v = csr_shadow[CSR_WIN_LEN_A + w];
      return (v < 1) ? 1 : v;
   endfunction

   function automatic void accumulate(ref longint unsigned total, ref int unsigned count,
                                      input longint unsigned v);
      longint unsigned n;
      n = total + v;
      if (n < v) begin
         total = 0;
         count = 0;
      end else begin
         total = n;
         count = count + 1;
      end
   endfunction

   function automatic void retire_seconds(int unsigned now);
      int unsigned nw, ns, nm, span, len, slot, ri, wi;
      longint unsigned target, walk, k;
      nw = clamp_count(csr_shadow[CSR_WINDOWS], WINDOWS);
      ns = clamp_count(csr_shadow[CSR_SPLITS], SPLITS);
      nm = clamp_count(csr_shadow[CSR_METRICS], METRICS);
      span = ring_span();
      busy_estimate = 200;
      for (int w = 0; w < nw; w++) begin
         len = window_span(w);
         if (longint'(now) + 1 < len) continue;
         target = longint'(now) + 1 - len;
         if (expired_to[w] >= target) continue;
         walk = target - expired_to[w];
         if (walk > span) walk = span;
         busy_estimate += 66 + 2 * int'(walk) * ns * nm;
         for (k = 0; k < walk; k++) begin
            slot = (longint'(expired_to[w]) + k) % span;
            for (int s = 0; s < ns; s++) begin
               for (int m = 0; m < nm; m++) begin
                  ri = slot * GROUP + s * METRICS + m;
                  wi = w * GROUP + s * METRICS + m;
                  win_total[wi] = win_total[wi] - ring_total[ri];
                  win_count[wi] = win_count[wi] - ring_count[ri];
                  if (len == span) begin
                     ring_total[ri] = 0;
                     ring_count[ri] = 0;
                  end
               end
            end
         end
         expired_to[w] = target[31:0];
      end
   endfunction

   function automatic logic [63:0] mean_in_milli(longint unsigned total, int unsigned count);
      longint unsigned q, r, base, frac;
      if (count == 0) return 0;
      q = total / count;
      r = total % count;
      if (q > ALL_ONES / 1000) return ALL_ONES;
      base = q * 1000;
      frac = (r * 2000 + count) / (longint'(count) * 2);
      if (base + frac < base) return ALL_ONES;
      return base + frac;
   endfunction

   function automatic void predict_request(req_type r);
      int unsigned nw, ns, nm, idx, slot;
      rsp_type o;
      nw = clamp_count(csr_shadow[CSR_WINDOWS], WINDOWS);
      ns = clamp_count(csr_shadow[CSR_SPLITS], SPLITS);
      nm = clamp_count(csr_shadow[CSR_METRICS], METRICS);
      if (r.command == CMD_SAMPLE) begin
         retire_seconds(r.now_seconds);
         if (r.split_index >= ns || r.metric_index >= nm) return;
         idx = r.split_index * METRICS + r.metric_index;
         slot = r.now_seconds % ring_span();
         accumulate(ring_total[slot*GROUP+idx], ring_count[slot*GROUP+idx], r.sample_value);
         for (int w = 0; w < nw; w++)
            accumulate(win_total[w*GROUP+idx], win_count[w*GROUP+idx], r.sample_value);
         return;
      end
      // a report in the same second as the last one is silent
      if (r.now_seconds == last_report_sec) return;
      last_report_sec = r.now_seconds;
      retire_seconds(r.now_seconds);
      for (int w = 0; w < nw; w++) begin
         for (int s = 0; s < ns; s++) begin
            for (int m = 0; m < nm; m++) begin
               idx = w * GROUP + s * METRICS + m;
               o.window_index = 2'(w);
               o.split_out = 2'(s);
               o.metric_out = 2'(m);
               o.mean_milli = mean_in_milli(win_total[idx], win_count[idx]);
               o.report_time = r.now_seconds;
               o.last_of_report = (w == nw - 1 && s == ns - 1 && m == nm - 1);
               pending_means.push_back(o);
            end
         end
      end
   endfunction

   // result checker and receiver stalls
   always @(posedge clock) begin
      rsp_type e;
      if (reset) begin
         rsp_stall <= 1'b0;
         recv_wait = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_means.size() == 0) begin
               $error("unexpected result window %0d split %0d metric %0d",
                      rsp_data.window_index, rsp_data.split_out, rsp_data.metric_out);
               error_count++;
            end else begin
               e = pending_means.pop_front();
               if (rsp_data.window_index !== e.window_index) begin
                  $error("window_index exp %0d got %0d", e.window_index, rsp_data.window_index);
                  error_count++;
               end
               if (rsp_data.split_out !== e.split_out) begin
                  $error("split_out exp %0d got %0d", e.split_out, rsp_data.split_out);
                  error_count++;
               end
               if (rsp_data.metric_out !== e.metric_out) begin
                  $error("metric_out exp %0d got %0d", e.metric_out, rsp_data.metric_out);
                  error_count++;
               end
               if (rsp_data.mean_milli !== e.mean_milli) begin
                  $error("mean_milli exp %0d got %0d", e.mean_milli, rsp_data.mean_milli);
                  error_count++;
               end
               if (rsp_data.report_time !== e.report_time) begin
                  $error("report_time exp %0d got %0d", e.report_time, rsp_data.report_time);
                  error_count++;
               end
               if (rsp_data.last_of_report !== e.last_of_report) begin
                  $error("last_of_report exp %0d got %0d",
                         e.last_of_report, rsp_data.last_of_report);
                  error_count++;
               end
            end
            recv_wait = recv_idle ? $urandom_range(0, 17) : 0;
         end
         if (hold_req != hold_seen) begin
            hold_seen = hold_req;
            recv_wait = hold_cycles;
         end
         if (recv_wait > 0) begin
            recv_wait--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   function automatic req_type make_req(logic cmd, logic [31:0] now, logic [1:0] s,
                                        logic [1:0] m, logic [63:0] v);
      req_type r;
      r.command = cmd;
      r.now_seconds = now;
      r.split_index = s;
      r.metric_index = m;
      r.sample_value = v;
      return r;
   endfunction

   task automatic send_request(req_type r);
      int gap;
      gap = send_idle ? $urandom_range(0, 17) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (req_stall);
      predict_request(r);
   endtask

   // let the block finish all work before touching the registers
   task automatic drain_requests();
      req_valid <= 1'b0;
      while (pending_means.size() != 0) @(posedge clock);
      repeat (busy_estimate + 200) @(posedge clock);
   endtask

   task automatic write_regs(int unsigned vals[CFG_REGS]);
      for (int i = 0; i < CFG_REGS; i++) begin
         csr_write <= 1'b1;
         csr_index <= CSR_INDEX_BITS'(i);
         csr_data <= CFG_BITS'(vals[i]);
         @(posedge clock);
         csr_shadow[i] = vals[i] & ((i < 3) ? 7 : 1023);
      end
      csr_write <= 1'b0;
   endtask

   function automatic logic [63:0] random_value();
      case ($urandom_range(0, 3))
         0: return {$urandom, $urandom};
         1: return ALL_ONES - $urandom_range(0, 1000);
         default: return $urandom_range(0, 100000);
      endcase
   endfunction

   task automatic random_requests(int count, int report_pct);
      logic cmd;
      int unsigned ns, nm, jump;
      logic [1:0] s, m;
      for (int n = 0; n < count; n++) begin
         ns = clamp_count(csr_shadow[CSR_SPLITS], SPLITS);
         nm = clamp_count(csr_shadow[CSR_METRICS], METRICS);
         if ($urandom_range(0, 49) == 0) jump = $urandom_range(0, ring_span() + 5);
         else jump = $urandom_range(0, 2);
         clock_sec += jump;
         cmd = ($urandom_range(0, 99) < report_pct) ? CMD_REPORT : CMD_SAMPLE;
         if ($urandom_range(0, 9) == 0) begin
            s = 2'($urandom);
            m = 2'($urandom);
         end else begin
            s = 2'($urandom_range(0, ns - 1));
            m = 2'($urandom_range(0, nm - 1));
         end
         send_request(make_req(cmd, clock_sec, s, m, random_value()));
      end
   endtask

   task automatic test_defaults();
      send_request(make_req(CMD_SAMPLE, 0, 0, 0, 64'd5));
      send_request(make_req(CMD_REPORT, 0, 3, 3, 64'd0));
      send_request(make_req(CMD_SAMPLE, 1, 2, 1, 64'd9));
      send_request(make_req(CMD_SAMPLE, 1, 0, 0, 64'd6));
      send_request(make_req(CMD_REPORT, 1, 0, 0, ALL_ONES));
      clock_sec = 1;
      drain_requests();
   endtask

   task automatic test_full_config();
      int unsigned cfg[CFG_REGS] = '{4, 4, 4, 8, 1, 3, 8, 5};
      write_regs(cfg);
      clock_sec = 10;
      send_request(make_req(CMD_SAMPLE, 10, 3, 3, ALL_ONES));
      send_request(make_req(CMD_SAMPLE, 10, 0, 0, 64'd1));
      send_request(make_req(CMD_SAMPLE, 10, 0, 0, 64'd2));
      send_request(make_req(CMD_REPORT, 11, 0, 0, 64'd0));
      send_request(make_req(CMD_REPORT, 11, 0, 0, 64'd0));
      send_request(make_req(CMD_SAMPLE, 12, 3, 3, 64'd1));
      send_request(make_req(CMD_SAMPLE, 13, 1, 2, 64'd7));
      send_request(make_req(CMD_SAMPLE, 13, 1, 2, 64'd8));
      send_request(make_req(CMD_REPORT, 20, 0, 0, 64'd0));
      clock_sec = 20;
      drain_requests();
   endtask

   task automatic test_odd_settings();
      int unsigned zeros[CFG_REGS] = '{0, 0, 0, 0, 0, 0, 0, 0};
      int unsigned tops[CFG_REGS] = '{7, 7, 7, 1023, 512, 1023, 300, 2};
      write_regs(zeros);
      send_request(make_req(CMD_SAMPLE, 21, 1, 0, 64'd4));
      send_request(make_req(CMD_SAMPLE, 21, 0, 0, 64'd4));
      send_request(make_req(CMD_REPORT, 22, 0, 0, 64'd0));
      drain_requests();
      write_regs(tops);
      send_request(make_req(CMD_SAMPLE, 30, 3, 3, 64'd123456));
      // long idle gap and a jump near the top of the seconds range
      send_request(make_req(CMD_SAMPLE, 2000, 2, 2, 64'd99));
      send_request(make_req(CMD_REPORT, 32'hFFFF_FF00, 0, 0, 64'd0));
      // seconds going back
      send_request(make_req(CMD_SAMPLE, 40, 1, 1, 64'd3));
      send_request(make_req(CMD_REPORT, 41, 0, 0, 64'd0));
      clock_sec = 41;
      drain_requests();
   endtask

   task automatic test_random_settings();
      int unsigned cfg[CFG_REGS];
      int unsigned span;
      for (int p = 0; p < 4; p++) begin
         span = (p == 0) ? 512 : $urandom_range(1, 24);
         cfg[CSR_WINDOWS] = (p == 0) ? 4 : $urandom_range(1, 4);
         cfg[CSR_SPLITS] = (p == 0) ? 4 : $urandom_range(1, 4);
         cfg[CSR_METRICS] = (p == 0) ? 4 : $urandom_range(1, 4);
         cfg[CSR_LONGEST] = span;
         for (int w = 0; w < 4; w++)
            cfg[CSR_WIN_LEN_A + w] = ($urandom_range(0, 2) == 0) ? span
                                     : $urandom_range(1, span);
         write_regs(cfg);
         send_idle = (p != 2);
         recv_idle = (p != 2);
         random_requests((p == 0) ? 40 : 50, (p == 0) ? 8 : 15);
         drain_requests();
      end
      send_idle = 1'b1;
      recv_idle = 1'b1;
   endtask

   task automatic test_backpressure();
      int unsigned cfg[CFG_REGS] = '{2, 2, 2, 6, 6, 3, 1, 1};
      write_regs(cfg);
      @(posedge clock);
      hold_cycles = 6000;
      hold_req++;
      send_idle = 1'b0;
      random_requests(30, 40);
      // sender waits for every result before going on
      req_valid <= 1'b0;
      while (pending_means.size() != 0) @(posedge clock);
      send_idle = 1'b1;
      random_requests(20, 20);
      drain_requests();
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_write = 1'b0;
      csr_index = '0;
      csr_data = '0;
      send_idle = 1'b1;
      recv_idle = 1'b1;
      clock_sec = 0;
      foreach (ring_total[i]) begin
         ring_total[i] = 0;
         ring_count[i] = 0;
      end
      foreach (win_total[i]) begin
         win_total[i] = 0;
         win_count[i] = 0;
      end
      foreach (expired_to[i]) expired_to[i] = 0;
      foreach (csr_shadow[i]) csr_shadow[i] = 1;
      last_report_sec = 0;
      busy_estimate = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_defaults();
      test_full_config();
      test_odd_settings();
      test_random_settings();
      test_backpressure();
      if (error_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   initial begin
      #(64'd3_000_000_000);
      $display("RESULT: ERROR");
      $finish;
   end

endmodule
